/* design/ooktpg_pkg.sv */
// ----------------------------------------------------------------------------
// ooktpg_pkg
// Types, register indexes, reset values and small helpers for the on-off
// keyed ternary pulse group encoder.
// ----------------------------------------------------------------------------
package ooktpg_pkg;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_ALARM = 1'b1
    } req_type_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_REPEAT_COUNT  = 3'd0,
        CFG_DIGIT_COUNT   = 3'd1,
        CFG_PULSE_HIGH_US = 3'd2,
        CFG_PULSE_GAP_US  = 3'd3,
        CFG_GROUP_END_US  = 3'd4,
        CFG_HEADER_LOW_US = 3'd5,
        CFG_REPEAT_GAP_US = 3'd6
    } cfg_index_t;

    // Frame sequencer phases, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE       = 7'b000_0001,
        PH_HEADER     = 7'b000_0010,
        PH_HEADER_END = 7'b000_0100,
        PH_REPEAT     = 7'b000_1000,
        PH_NEXT_GROUP = 7'b001_0000,
        PH_GROUP_HIGH = 7'b010_0000,
        PH_GROUP_LOW  = 7'b100_0000
    } phase_t;

    localparam int unsigned CMD_MAX_W  = 64;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [HOLD_W-1:0] START_DELAY_US = 16'd15;

    localparam logic [7:0]        RST_REPEAT_COUNT  = 8'd5;
    localparam logic [5:0]        RST_DIGIT_COUNT   = 6'd33;
    localparam logic [HOLD_W-1:0] RST_PULSE_HIGH_US = 16'd300;
    localparam logic [HOLD_W-1:0] RST_PULSE_GAP_US  = 16'd220;
    localparam logic [HOLD_W-1:0] RST_GROUP_END_US  = 16'd1300;
    localparam logic [HOLD_W-1:0] RST_HEADER_LOW_US = 16'd2560;
    localparam logic [HOLD_W-1:0] RST_REPEAT_GAP_US = 16'd10000;

    // (4^32 - 1) / 3 and twice that. The negated first one is the inverse of
    // three modulo any power of two up to 2^64.
    localparam logic [CMD_MAX_W-1:0] THIRD_ONE = 64'h5555_5555_5555_5555;
    localparam logic [CMD_MAX_W-1:0] THIRD_TWO = 64'hAAAA_AAAA_AAAA_AAAA;

    // Remainder modulo three of a small folded value.
    function automatic logic [1:0] mod3_small(input logic [3:0] val);
        logic [1:0] res;
        case (val)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: res = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       res = 2'd1;
            default:                              res = 2'd2;
        endcase
        return res;
    endfunction

endpackage

/* design/ook_ternary_pulse_group_encoder.sv */
// ----------------------------------------------------------------------------
// ook_ternary_pulse_group_encoder
// Sequences the line levels and hold times of a repeated pulse group frame
// that carries a command word as base-3 digits, one result per item.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Contents
//  ---------+--------------------------------+----------------------------------
//  input    | s_tvalid s_tready s_tdata      | tdata: command_word; tuser: req_type
//           | s_tuser                        |
//  result   | m_tvalid m_tready m_tdata      | tdata: line_level, hold_us, done_res
//  config   | cfg_wr_en cfg_index cfg_wdata  | one register written per enabled edge
//
// Every item is answered with one result, registered at the edge that
// accepts the item, and a new item is taken in every cycle in which the
// result register is empty or being emptied. The quotient and remainder of
// the digit value by three are prepared in two halves, with a register
// between them, before that value is next used. Reset is synchronous and
// returns the sequencer to idle with the registers at their default values.
// ----------------------------------------------------------------------------
module ook_ternary_pulse_group_encoder #(
    parameter int unsigned COMMAND_WIDTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ooktpg_pkg::CMD_MAX_W-1:0]     s_tdata,   // [63:0] command_word
    input  logic [0:0]                           s_tuser,   // [0] req_type
    // Result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ooktpg_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] line_level,
                                                            // [16:1] hold_us,
                                                            // [17] done_res
    // Configuration
    input  logic                                 cfg_wr_en,
    input  logic [2:0]                           cfg_index,
    input  logic [ooktpg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int unsigned W      = COMMAND_WIDTH;
    localparam int unsigned HOLD_W = ooktpg_pkg::HOLD_W;

    // Configuration registers
    logic [7:0]        repeat_count_reg;
    logic [5:0]        digit_count_reg;
    logic [HOLD_W-1:0] pulse_high_us_reg;
    logic [HOLD_W-1:0] pulse_gap_us_reg;
    logic [HOLD_W-1:0] group_end_us_reg;
    logic [HOLD_W-1:0] header_low_us_reg;
    logic [HOLD_W-1:0] repeat_gap_us_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_count_reg  <= ooktpg_pkg::RST_REPEAT_COUNT;
            digit_count_reg   <= ooktpg_pkg::RST_DIGIT_COUNT;
            pulse_high_us_reg <= ooktpg_pkg::RST_PULSE_HIGH_US;
            pulse_gap_us_reg  <= ooktpg_pkg::RST_PULSE_GAP_US;
            group_end_us_reg  <= ooktpg_pkg::RST_GROUP_END_US;
            header_low_us_reg <= ooktpg_pkg::RST_HEADER_LOW_US;
            repeat_gap_us_reg <= ooktpg_pkg::RST_REPEAT_GAP_US;
        end else if (cfg_wr_en) begin
            case (ooktpg_pkg::cfg_index_t'(cfg_index))
                ooktpg_pkg::CFG_REPEAT_COUNT:  repeat_count_reg  <= cfg_wdata[7:0];
                ooktpg_pkg::CFG_DIGIT_COUNT:   digit_count_reg   <= cfg_wdata[5:0];
                ooktpg_pkg::CFG_PULSE_HIGH_US: pulse_high_us_reg <= cfg_wdata;
                ooktpg_pkg::CFG_PULSE_GAP_US:  pulse_gap_us_reg  <= cfg_wdata;
                ooktpg_pkg::CFG_GROUP_END_US:  group_end_us_reg  <= cfg_wdata;
                ooktpg_pkg::CFG_HEADER_LOW_US: header_low_us_reg <= cfg_wdata;
                ooktpg_pkg::CFG_REPEAT_GAP_US: repeat_gap_us_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer state
    ooktpg_pkg::phase_t phase_reg, phase_next;
    logic [W-1:0]       saved_command_reg, saved_command_next;
    logic [W-1:0]       value_reg, value_next;
    logic [5:0]         digits_left_reg, digits_left_next;
    logic [7:0]         repeats_left_reg, repeats_left_next;
    logic [1:0]         pulses_left_reg, pulses_left_next;
    logic               level_now_reg, level_now_next;

    // Output register
    logic               m_tvalid_reg;
    logic               line_level_reg;
    logic [HOLD_W-1:0]  hold_us_reg;
    logic               done_res_reg;

    logic               in_fire;
    logic [HOLD_W-1:0]  hold_next;
    logic               done_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Division of the digit value by three, first half: remainder by
    // folding (2^2k is one modulo three) and the first three factors of
    // the multiplicative inverse.
    // ------------------------------------------------------------------
    logic [ooktpg_pkg::CMD_MAX_W-1:0] fold_in;
    logic [32:0]  fold_a;
    logic [17:0]  fold_b;
    logic [10:0]  fold_c;
    logic [7:0]   fold_d;
    logic [4:0]   fold_e;
    logic [3:0]   fold_f;
    logic [W-1:0] part_p1, part_p2, part_p3;
    logic [1:0]   div_rem_reg;
    logic [W-1:0] div_part_reg;

    always_comb begin
        fold_in = ooktpg_pkg::CMD_MAX_W'(value_reg);
        fold_a  = {1'b0, fold_in[63:32]} + {1'b0, fold_in[31:0]};
        fold_b  = 18'(fold_a[32:16]) + 18'(fold_a[15:0]);
        fold_c  = 11'(fold_b[17:8]) + 11'(fold_b[7:0]);
        fold_d  = 8'(fold_c[10:4]) + 8'(fold_c[3:0]);
        fold_e  = 5'(fold_d[7:4]) + 5'(fold_d[3:0]);
        fold_f  = 4'(fold_e[4:2]) + 4'(fold_e[1:0]);

        part_p1 = value_reg + (value_reg << 2);
        part_p2 = part_p1 + (part_p1 << 4);
        part_p3 = part_p2 + (part_p2 << 8);
    end

    always_ff @(posedge aclk) begin
        div_rem_reg  <= ooktpg_pkg::mod3_small(fold_f);
        div_part_reg <= part_p3;
    end

    // Second half: finish the inverse product and correct by the remainder.
    logic [W-1:0] part_p4, part_p5, rem_term, div_quot;

    always_comb begin
        part_p4 = div_part_reg + (div_part_reg << 16);
        part_p5 = part_p4 + (part_p4 << 32);
        case (div_rem_reg)
            2'd0:    rem_term = '0;
            2'd1:    rem_term = ooktpg_pkg::THIRD_ONE[W-1:0];
            default: rem_term = ooktpg_pkg::THIRD_TWO[W-1:0];
        endcase
        div_quot = rem_term - part_p5;
    end

    // ------------------------------------------------------------------
    // Frame sequencer
    // ------------------------------------------------------------------
    always_comb begin
        phase_next         = phase_reg;
        saved_command_next = saved_command_reg;
        value_next         = value_reg;
        digits_left_next   = digits_left_reg;
        repeats_left_next  = repeats_left_reg;
        pulses_left_next   = pulses_left_reg;
        level_now_next     = level_now_reg;
        hold_next          = '0;
        done_next          = 1'b0;

        if (ooktpg_pkg::req_type_t'(s_tuser[0]) == ooktpg_pkg::REQ_START) begin
            saved_command_next = s_tdata[W-1:0];
            value_next         = s_tdata[W-1:0];
            digits_left_next   = digit_count_reg;
            repeats_left_next  = repeat_count_reg;
            pulses_left_next   = 2'd0;
            phase_next         = ooktpg_pkg::PH_HEADER;
            hold_next          = ooktpg_pkg::START_DELAY_US;
        end else begin
            case (phase_reg)
                ooktpg_pkg::PH_HEADER: begin
                    level_now_next = 1'b1;
                    phase_next     = ooktpg_pkg::PH_HEADER_END;
                    hold_next      = pulse_high_us_reg;
                end
                ooktpg_pkg::PH_HEADER_END: begin
                    level_now_next = 1'b0;
                    phase_next     = ooktpg_pkg::PH_NEXT_GROUP;
                    hold_next      = header_low_us_reg;
                end
                ooktpg_pkg::PH_REPEAT: begin
                    level_now_next = 1'b0;
                    phase_next     = ooktpg_pkg::PH_HEADER;
                    hold_next      = repeat_gap_us_reg;
                end
                ooktpg_pkg::PH_NEXT_GROUP: begin
                    level_now_next = 1'b1;
                    if (digits_left_reg != 6'd0) begin
                        pulses_left_next = div_rem_reg + 2'd1;
                        value_next       = div_quot;
                        digits_left_next = digits_left_reg - 6'd1;
                        phase_next       = ooktpg_pkg::PH_GROUP_HIGH;
                        hold_next        = pulse_high_us_reg;
                    end else if (repeats_left_reg > 8'd1) begin
                        repeats_left_next = repeats_left_reg - 8'd1;
                        value_next        = saved_command_reg;
                        digits_left_next  = digit_count_reg;
                        phase_next        = ooktpg_pkg::PH_REPEAT;
                        hold_next         = pulse_high_us_reg;
                    end else begin
                        phase_next = ooktpg_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                ooktpg_pkg::PH_GROUP_HIGH: begin
                    level_now_next = 1'b0;
                    if (pulses_left_reg > 2'd1) begin
                        pulses_left_next = pulses_left_reg - 2'd1;
                        phase_next       = ooktpg_pkg::PH_GROUP_LOW;
                        hold_next        = pulse_gap_us_reg;
                    end else begin
                        phase_next = ooktpg_pkg::PH_NEXT_GROUP;
                        hold_next  = group_end_us_reg;
                    end
                end
                ooktpg_pkg::PH_GROUP_LOW: begin
                    level_now_next = 1'b1;
                    phase_next     = ooktpg_pkg::PH_GROUP_HIGH;
                    hold_next      = pulse_high_us_reg;
                end
                default: begin
                    // Alarm with no transmission running.
                    phase_next = ooktpg_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= ooktpg_pkg::PH_IDLE;
            saved_command_reg <= '0;
            value_reg         <= '0;
            digits_left_reg   <= '0;
            repeats_left_reg  <= '0;
            pulses_left_reg   <= '0;
            level_now_reg     <= 1'b0;
        end else if (in_fire) begin
            phase_reg         <= phase_next;
            saved_command_reg <= saved_command_next;
            value_reg         <= value_next;
            digits_left_reg   <= digits_left_next;
            repeats_left_reg  <= repeats_left_next;
            pulses_left_reg   <= pulses_left_next;
            level_now_reg     <= level_now_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            line_level_reg <= level_now_next;
            hold_us_reg    <= hold_next;
            done_res_reg   <= done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, done_res_reg, hold_us_reg, line_level_reg};

`ifndef SYNTHESIS
    // A finishing result always leaves the sequencer idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && done_next) |=> (phase_reg == ooktpg_pkg::PH_IDLE))
        else $error("done reported but sequencer not idle");

    // The prepared quotient and remainder must reconstruct the digit value
    // whenever a digit is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser[0] && phase_reg == ooktpg_pkg::PH_NEXT_GROUP
         && digits_left_reg != 6'd0)
        |-> (div_quot + (div_quot << 1) + W'(div_rem_reg) == value_reg))
        else $error("divide by three out of step with digit value");

    // Between two pulses of a group there is always a pulse still to send.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == ooktpg_pkg::PH_GROUP_LOW) |-> (pulses_left_reg != 2'd0))
        else $error("gap phase with no pulse left");

    // The line is low whenever the sequencer waits inside a group gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == ooktpg_pkg::PH_GROUP_LOW || phase_reg == ooktpg_pkg::PH_NEXT_GROUP)
        |-> !level_now_reg)
        else $error("line high during a low phase");
`endif

endmodule
